// ----- rtl/gwm_pkg.sv -----
// Shared constants, codes and controller/datapath types for the glob matcher.
package gwm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam int unsigned ELEM_MAX_DEF    = 16;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ANY   = 8'h3F;
  localparam logic [7:0] CH_ESC   = 8'h5C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;

  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL,
    OP_LIT,
    OP_CLEAR,
    OP_TOGGLE,
    OP_ADD,
    OP_RANGE,
    OP_CLOSE,
    OP_CLOSE_DASH
  } dp_op_e;

  typedef struct packed {
    logic   first;
    logic   adv;
    dp_op_e op;
    logic   fin;
    logic   bad;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_end;
    logic full;
    logic ovf;
    logic have_prev;
    logic is_star;
    logic is_any;
    logic is_esc;
    logic is_open;
    logic is_close;
    logic is_dash;
    logic is_neg;
  } dp_stat_t;

endpackage

// ----- rtl/gwm_ctrl.sv -----
// Compile sequencer: walks the stored pattern and steers the datapath.
module gwm_ctrl import gwm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_PREP     = 8'b0000_0010,
    S_TOP      = 8'b0000_0100,
    S_ESC      = 8'b0000_1000,
    S_SET      = 8'b0001_0000,
    S_SET_ESC  = 8'b0010_0000,
    S_DASH     = 8'b0100_0000,
    S_DASH_ESC = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{first: 1'b0, adv: 1'b0, op: OP_NONE, fin: 1'b0, bad: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (go_i) state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.first = 1'b1;
        if (stat_i.ovf) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        if (stat_i.at_end) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end else if (stat_i.full) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          if (stat_i.is_star || stat_i.is_any) begin
            cmd_o.op = OP_FILL;
          end else if (stat_i.is_esc) begin
            state_d = S_ESC;
          end else if (stat_i.is_open) begin
            cmd_o.op = OP_CLEAR;
            state_d  = S_SET;
          end else begin
            cmd_o.op = OP_LIT;
          end
        end
      end
      S_ESC: begin
        if (stat_i.at_end) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          cmd_o.op  = OP_LIT;
          state_d   = S_TOP;
        end
      end
      S_SET: begin
        if (stat_i.at_end) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          if (stat_i.is_close) begin
            cmd_o.op = OP_CLOSE;
            state_d  = S_TOP;
          end else if (stat_i.is_neg) begin
            cmd_o.op = OP_TOGGLE;
          end else if (stat_i.is_esc) begin
            state_d = S_SET_ESC;
          end else if (stat_i.is_dash && stat_i.have_prev) begin
            state_d = S_DASH;
          end else begin
            cmd_o.op = OP_ADD;
          end
        end
      end
      S_SET_ESC: begin
        if (stat_i.at_end) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          cmd_o.op  = OP_ADD;
          state_d   = S_SET;
        end
      end
      S_DASH: begin
        if (stat_i.at_end) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          // A dash right before the closing bracket is a plain member.
          if (stat_i.is_close) begin
            cmd_o.op = OP_CLOSE_DASH;
            state_d  = S_TOP;
          end else if (stat_i.is_esc) begin
            state_d = S_DASH_ESC;
          end else begin
            cmd_o.op = OP_RANGE;
            state_d  = S_SET;
          end
        end
      end
      S_DASH_ESC: begin
        if (stat_i.at_end) begin
          cmd_o.fin = 1'b1;
          cmd_o.bad = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          cmd_o.op  = OP_RANGE;
          state_d   = S_SET;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/gwm_dp.sv -----
// Datapath: pattern memory, class builder, element registers and the NFA.
module gwm_dp import gwm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned ELEM_MAX    = ELEM_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       cmd_i,
  input  logic [7:0] byte_value_i,
  input  logic       last_i,
  input  ctrl_cmd_t  cmd_ctl_i,
  output dp_stat_t   stat_o,
  output logic       done_o,
  output logic [1:0] status_o
);

  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned PW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned EW = (ELEM_MAX > 1) ? $clog2(ELEM_MAX) : 1;
  localparam int unsigned CW = $clog2(ELEM_MAX + 1);

  logic [7:0]   mem_q [PATTERN_MAX];
  logic [7:0]   rdata_q;
  logic [PW-1:0] raw_len_q, pos_q, pos_d;
  logic         ovf_q;

  logic [255:0] cls_q [ELEM_MAX];
  logic [ELEM_MAX-1:0] star_q;
  logic [CW-1:0] cnt_q, count_q;
  logic [ELEM_MAX:0] act_q, nxt;
  logic         inv_q;

  logic [255:0] acc_q, range_mask, onehot, set_val;
  logic         neg_q, hp_q;
  logic [7:0]   prev_q;
  logic         done_q;
  logic [1:0]   status_q;
  logic         ld, txt, elem_wr;
  logic [255:0] elem_val;

  assign ld  = accept_i && (cmd_i == CMD_PATTERN);
  assign txt = accept_i && (cmd_i == CMD_TEXT);

  // Pattern memory: one write port for loading, one registered read port.
  always_comb begin
    pos_d = pos_q;
    if (cmd_ctl_i.first) begin
      pos_d = '0;
    end else if (cmd_ctl_i.adv) begin
      pos_d = pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && (raw_len_q < PW'(PATTERN_MAX))) begin
      mem_q[raw_len_q[AW-1:0]] <= byte_value_i;
    end
    rdata_q <= mem_q[pos_d[AW-1:0]];
  end

  always_comb begin
    stat_o.at_end    = (pos_q == raw_len_q);
    stat_o.full      = (cnt_q == CW'(ELEM_MAX));
    stat_o.ovf       = ovf_q;
    stat_o.have_prev = hp_q;
    stat_o.is_star   = (rdata_q == CH_STAR);
    stat_o.is_any    = (rdata_q == CH_ANY);
    stat_o.is_esc    = (rdata_q == CH_ESC);
    stat_o.is_open   = (rdata_q == CH_OPEN);
    stat_o.is_close  = (rdata_q == CH_CLOSE);
    stat_o.is_dash   = (rdata_q == CH_DASH);
    stat_o.is_neg    = (rdata_q == CH_BANG) || (rdata_q == CH_CARET);
  end

  always_comb begin
    for (int v = 0; v < 256; v++) begin
      range_mask[v] = (8'(v) >= prev_q) && (8'(v) <= rdata_q);
      onehot[v]     = (8'(v) == rdata_q);
    end
    set_val = acc_q;
    if (cmd_ctl_i.op == OP_CLOSE_DASH) set_val[CH_DASH] = 1'b1;
    if (neg_q) set_val = ~set_val;
  end

  always_comb begin
    elem_wr  = 1'b0;
    elem_val = onehot;
    case (cmd_ctl_i.op)
      OP_FILL: begin
        elem_wr  = 1'b1;
        elem_val = '1;
      end
      OP_LIT: begin
        elem_wr = 1'b1;
      end
      OP_CLOSE, OP_CLOSE_DASH: begin
        elem_wr  = 1'b1;
        elem_val = set_val;
      end
      default: begin
        elem_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (elem_wr) begin
      cls_q[cnt_q[EW-1:0]]  <= elem_val;
      star_q[cnt_q[EW-1:0]] <= (cmd_ctl_i.op == OP_FILL) && stat_o.is_star;
    end
    case (cmd_ctl_i.op)
      OP_CLEAR:  acc_q <= '0;
      OP_ADD:    acc_q <= acc_q | onehot;
      OP_RANGE:  acc_q <= acc_q | range_mask;
      default:   acc_q <= acc_q;
    endcase
    if (cmd_ctl_i.op == OP_ADD) prev_q <= rdata_q;
  end

  // Bit-parallel NFA step over all elements at once.
  always_comb begin
    nxt    = '0;
    for (int i = 0; i < ELEM_MAX; i++) begin
      nxt[i+1] = (CW'(i) < count_q) && (act_q[i] || (star_q[i] && act_q[i+1]))
                 && cls_q[i][byte_value_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_len_q <= '0;
      ovf_q     <= 1'b0;
      pos_q     <= '0;
      cnt_q     <= '0;
      count_q   <= '0;
      inv_q     <= 1'b0;
      act_q     <= (ELEM_MAX+1)'(1);
      neg_q     <= 1'b0;
      hp_q      <= 1'b0;
      done_q    <= 1'b0;
      status_q  <= ST_MATCH;
    end else begin
      pos_q  <= pos_d;
      done_q <= 1'b0;
      if (ld) begin
        if (raw_len_q < PW'(PATTERN_MAX)) begin
          raw_len_q <= raw_len_q + PW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_ctl_i.first) cnt_q <= '0;
      if (elem_wr) cnt_q <= cnt_q + CW'(1);
      case (cmd_ctl_i.op)
        OP_CLEAR: begin
          neg_q <= 1'b0;
          hp_q  <= 1'b0;
        end
        OP_TOGGLE: begin
          neg_q <= ~neg_q;
          hp_q  <= 1'b0;
        end
        OP_ADD:   hp_q <= 1'b1;
        OP_RANGE: hp_q <= 1'b0;
        default:  hp_q <= hp_q;
      endcase
      if (cmd_ctl_i.fin) begin
        raw_len_q <= '0;
        ovf_q     <= 1'b0;
        inv_q     <= cmd_ctl_i.bad;
        count_q   <= cmd_ctl_i.bad ? '0 : cnt_q;
        act_q     <= (ELEM_MAX+1)'(1);
      end
      if (txt) begin
        if (last_i) begin
          done_q   <= 1'b1;
          status_q <= inv_q ? ST_INVALID : (nxt[count_q] ? ST_MATCH : ST_NOMATCH);
          act_q    <= (ELEM_MAX+1)'(1);
        end else begin
          act_q <= nxt;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

// ----- rtl/glob_wildcard_matcher.sv -----
// Top level of the glob matcher: controller, datapath and checks.
// Usage: present a transaction with start high while busy is low. cmd_i
// selects a pattern byte or a text byte, byte_value_i carries it and last_i
// marks the final byte of the pattern or of the text string.
// Pattern bytes are taken one per cycle into the pattern memory while busy
// is low. The last pattern byte starts a compile walk that reads one stored
// byte per cycle, paced by the single read port of the pattern memory; busy
// stays high until the walk ends at the pattern end, on an error or on an
// overflowed load. Text bytes are taken one per cycle while busy is low;
// all NFA positions advance in parallel from the element class registers.
// In the cycle after the last text byte, done_o pulses for one cycle with
// status_o: match, no match or invalid.
// The receiver cannot stall, so the result is lost if not captured then.
// After reset no pattern is compiled and every text string gives no match.
// Reset clears the control state; memories hold garbage until written.
module glob_wildcard_matcher import gwm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned ELEM_MAX    = ELEM_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cmd_i,
  input  logic [7:0] byte_value_i,
  input  logic       last_i,
  output logic       done_o,
  output logic [1:0] status_o
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      accept, go;

  assign accept = start && !busy;
  assign go     = accept && (cmd_i == CMD_PATTERN) && last_i;

  gwm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .stat_i (stat),
    .cmd_o  (ctl),
    .busy_o (busy)
  );

  gwm_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .ELEM_MAX    (ELEM_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .byte_value_i (byte_value_i),
    .last_i       (last_i),
    .cmd_ctl_i    (ctl),
    .stat_o       (stat),
    .done_o       (done_o),
    .status_o     (status_o)
  );

  // A result only follows the final byte of a text transaction.
  a_done_after_text_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && (cmd_i == CMD_TEXT) && last_i))
    else $error("result without a text end");

  // The compile walk only starts after the final pattern byte.
  a_busy_after_pattern_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (cmd_i == CMD_PATTERN) && last_i))
    else $error("busy without a pattern end");

  // No result can be produced while a compile is in progress.
  a_no_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !done_o)
    else $error("result during compile");

endmodule

// ----- sim/glob_wildcard_matcher_test.sv -----
// Self-checking testbench for the glob matcher: pattern and text streams against a predictor.
`timescale 1ns / 100ps

module glob_wildcard_matcher_test import gwm_pkg::*;;

  localparam int unsigned PAT_MAX  = PATTERN_MAX_DEF;
  localparam int unsigned ELEM_MAX = ELEM_MAX_DEF;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic       cmd;
    logic [7:0] val;
    logic       last;
  } byte_item_t;

  // Glob predictor and store of expected status values.
  class glob_scoreboard;
    logic [7:0]   pat_buf[$];
    logic         pat_ovf;
    logic [255:0] elem_cls[ELEM_MAX];
    logic         elem_star[ELEM_MAX];
    int unsigned  elem_cnt;
    logic         pat_bad;
    logic         nfa_pos[ELEM_MAX + 1];
    logic [1:0]   status_q[$];
    int unsigned  err_cnt;

    function new();
      pat_buf.delete();
      pat_ovf  = 1'b0;
      elem_cnt = 0;
      pat_bad  = 1'b0;
      err_cnt  = 0;
      foreach (elem_star[k]) begin
        elem_star[k] = 1'b0;
        elem_cls[k]  = '0;
      end
      restart_nfa();
    endfunction

    function void restart_nfa();
      foreach (nfa_pos[k]) nfa_pos[k] = 1'b0;
      nfa_pos[0] = 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_cnt++;
    endtask

    // Members lie in pat_buf[a..z-1]; each bang or caret toggles negation.
    function void build_set(int unsigned e, int unsigned a, int unsigned z);
      logic        neg;
      logic        have_prev;
      int unsigned prev;
      int unsigned hi;
      int unsigned k;
      logic [7:0]  c;
      neg = 1'b0;
      have_prev = 1'b0;
      prev = 0;
      k = a;
      while (k < z) begin
        c = pat_buf[k];
        if (c == CH_BANG || c == CH_CARET) begin
          neg = !neg;
          have_prev = 1'b0;
          k++;
        end else if (c == CH_ESC && k + 1 < z) begin
          prev = pat_buf[k + 1];
          elem_cls[e][prev] = 1'b1;
          have_prev = 1'b1;
          k += 2;
        end else if (c == CH_DASH && have_prev && k + 1 < z) begin
          if (pat_buf[k + 1] == CH_ESC && k + 2 < z) begin
            hi = pat_buf[k + 2];
            k += 3;
          end else begin
            hi = pat_buf[k + 1];
            k += 2;
          end
          for (int unsigned v = prev; v <= hi; v++) elem_cls[e][v] = 1'b1;
          have_prev = 1'b0;
        end else begin
          elem_cls[e][c] = 1'b1;
          prev = c;
          have_prev = 1'b1;
          k++;
        end
      end
      if (neg) elem_cls[e] = ~elem_cls[e];
    endfunction

    function void compile_glob();
      int unsigned n;
      int unsigned i;
      int unsigned cnt;
      int unsigned j;
      logic        bad;
      logic [7:0]  c;
      n = pat_buf.size();
      i = 0;
      cnt = 0;
      bad = pat_ovf;
      while (i < n && !bad) begin
        c = pat_buf[i];
        if (cnt >= ELEM_MAX) begin
          bad = 1'b1;
          break;
        end
        elem_cls[cnt]  = '0;
        elem_star[cnt] = 1'b0;
        if (c == CH_STAR) begin
          elem_cls[cnt]  = '1;
          elem_star[cnt] = 1'b1;
          i++;
        end else if (c == CH_ANY) begin
          elem_cls[cnt] = '1;
          i++;
        end else if (c == CH_ESC) begin
          if (i + 1 >= n) begin
            bad = 1'b1;
            break;
          end
          elem_cls[cnt][pat_buf[i + 1]] = 1'b1;
          i += 2;
        end else if (c == CH_OPEN) begin
          j = i + 1;
          while (j < n && pat_buf[j] != CH_CLOSE) j += (pat_buf[j] == CH_ESC) ? 2 : 1;
          if (j >= n) begin
            bad = 1'b1;
            break;
          end
          build_set(cnt, i + 1, j);
          i = j + 1;
        end else begin
          elem_cls[cnt][c] = 1'b1;
          i++;
        end
        cnt++;
      end
      pat_bad  = bad;
      elem_cnt = bad ? 0 : cnt;
      pat_buf.delete();
      pat_ovf = 1'b0;
      restart_nfa();
    endfunction

    function void note_input(logic cmd, logic [7:0] b, logic last);
      logic nxt[ELEM_MAX + 1];
      if (cmd == CMD_PATTERN) begin
        if (pat_buf.size() < PAT_MAX) pat_buf.push_back(b);
        else pat_ovf = 1'b1;
        if (last) compile_glob();
        return;
      end
      foreach (nxt[k]) nxt[k] = 1'b0;
      for (int unsigned i = 0; i < elem_cnt; i++)
        nxt[i + 1] = (nfa_pos[i] || (elem_star[i] && nfa_pos[i + 1])) && elem_cls[i][b];
      if (!last) begin
        nfa_pos = nxt;
        return;
      end
      if (pat_bad) status_q.push_back(ST_INVALID);
      else status_q.push_back(nxt[elem_cnt] ? ST_MATCH : ST_NOMATCH);
      restart_nfa();
    endfunction

    task check_result(logic [1:0] got);
      logic [1:0] want;
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", got));
        return;
      end
      want = status_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf("status got %0d expected %0d", got, want));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cmd_i;
  logic [7:0] byte_value_i;
  logic       last_i;
  logic       done_o;
  logic [1:0] status_o;

  glob_wildcard_matcher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .byte_value_i(byte_value_i),
    .last_i      (last_i),
    .done_o      (done_o),
    .status_o    (status_o)
  );

  glob_scoreboard glob_sb;
  byte_item_t     stim_q[$];
  int unsigned    idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic add_bytes(logic cmd, logic [7:0] vals[$]);
    byte_item_t it;
    foreach (vals[k]) begin
      it.cmd  = cmd;
      it.val  = vals[k];
      it.last = (k == vals.size() - 1);
      stim_q.push_back(it);
    end
  endtask

  task automatic add_str(logic cmd, string s);
    logic [7:0] vals[$];
    for (int k = 0; k < s.len(); k++) vals.push_back(s[k]);
    add_bytes(cmd, vals);
  endtask

  function automatic logic [7:0] pick_pat_byte();
    string alpha;
    alpha = "ab-*?[]\\!^c";
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_text_byte();
    string alpha;
    alpha = "abc-]!";
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  // Walks the pattern and emits a text that is likely to match it.
  function automatic void shape_text(logic [7:0] pat[$], ref logic [7:0] txt[$]);
    int unsigned i;
    i = 0;
    txt.delete();
    while (i < pat.size()) begin
      if (pat[i] == CH_ESC && i + 1 < pat.size()) begin
        txt.push_back(pat[i + 1]);
        i += 2;
      end else if (pat[i] == CH_OPEN) begin
        if (i + 1 < pat.size() && pat[i + 1] != CH_CLOSE) txt.push_back(pat[i + 1]);
        else txt.push_back("a");
        i++;
        while (i < pat.size() && pat[i] != CH_CLOSE) i++;
        i++;
      end else if (pat[i] == CH_STAR) begin
        repeat ($urandom_range(1, 3)) txt.push_back(pick_text_byte());
        i++;
      end else if (pat[i] == CH_ANY) begin
        txt.push_back(pick_text_byte());
        i++;
      end else begin
        txt.push_back(pat[i]);
        i++;
      end
    end
    if (txt.size() == 0) txt.push_back("a");
    if ($urandom_range(0, 3) == 0) txt[$urandom_range(0, txt.size() - 1)] = pick_text_byte();
    if ($urandom_range(0, 5) == 0) txt.push_back(pick_text_byte());
  endfunction

  task automatic build_stimulus();
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    logic [7:0] tmp[$];
    // Text before any pattern is compiled.
    add_str(CMD_TEXT, "ab");
    add_str(CMD_PATTERN, "abc");
    add_str(CMD_TEXT, "abc");
    add_str(CMD_TEXT, "abd");
    add_str(CMD_PATTERN, "a*c");
    add_str(CMD_TEXT, "abbc");
    add_str(CMD_TEXT, "ac");
    tmp = '{8'h00, CH_ANY, 8'hFF};
    add_bytes(CMD_PATTERN, tmp);
    tmp = '{8'h00, 8'h7E, 8'hFF};
    add_bytes(CMD_TEXT, tmp);
    add_str(CMD_PATTERN, "[!a-c][^\\]][]");
    add_str(CMD_TEXT, "d]a");
    add_str(CMD_PATTERN, "[a-][z-a][!^x]\\*");
    add_str(CMD_TEXT, "-zx*");
    add_str(CMD_PATTERN, "[a-\\z][\\!b]");
    add_str(CMD_TEXT, "q!");
    // Missing close bracket, dangling escape, too many elements, a full element table, overflow.
    add_str(CMD_PATTERN, "[abc");
    add_str(CMD_TEXT, "a");
    add_str(CMD_PATTERN, "ab\\");
    add_str(CMD_TEXT, "ab");
    add_str(CMD_PATTERN, "abcdefghijklmnopq");
    add_str(CMD_TEXT, "a");
    add_str(CMD_PATTERN, "abcdefghijklmnop");
    add_str(CMD_TEXT, "abcdefghijklmnop");
    tmp.delete();
    repeat (PAT_MAX + 2) tmp.push_back("?");
    add_bytes(CMD_PATTERN, tmp);
    add_str(CMD_TEXT, "x");
    while (stim_q.size() < 900) begin
      pat.delete();
      if ($urandom_range(0, 40) == 0) begin
        repeat ($urandom_range(PAT_MAX - 2, PAT_MAX + 4)) pat.push_back(pick_pat_byte());
      end else begin
        repeat ($urandom_range(1, 12)) pat.push_back(pick_pat_byte());
      end
      add_bytes(CMD_PATTERN, pat);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0) begin
          txt.delete();
          repeat ($urandom_range(1, 6)) txt.push_back(pick_text_byte());
        end else begin
          shape_text(pat, txt);
        end
        add_bytes(CMD_TEXT, txt);
      end
      // Noise: a stray single byte, pattern or text, that forms a transaction of its own.
      if ($urandom_range(0, 9) == 0) begin
        tmp = '{pick_text_byte()};
        add_bytes(1'($urandom_range(0, 1)), tmp);
      end
    end
  endtask

  task automatic drive_stream();
    int unsigned burst_left;
    int unsigned gap_left;
    logic        taken;
    byte_item_t  it;
    burst_left = $urandom_range(1, 20);
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      taken = start && !busy;
      if (start && !taken) continue;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (stim_q.size() == 0) begin
        start <= 1'b0;
        break;
      end else begin
        it = stim_q.pop_front();
        start        <= 1'b1;
        cmd_i        <= it.cmd;
        byte_value_i <= it.val;
        last_i       <= it.last;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) glob_sb.note_input(cmd_i, byte_value_i, last_i);
      if (done_o) glob_sb.check_result(status_o);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    glob_sb      = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_PATTERN;
    byte_value_i = 8'h00;
    last_i       = 1'b0;
    idle_cycles  = 0;
    build_stimulus();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    drive_stream();
    while (glob_sb.status_q.size() != 0) @(posedge clk_i);
    // The compile walk of a trailing pattern is allowed to finish.
    repeat (PAT_MAX + 10) @(posedge clk_i);
    if (glob_sb.status_q.size() != 0)
      glob_sb.report_mismatch("expected results left over");
    if (glob_sb.err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gwm_pkg.sv
rtl/gwm_ctrl.sv
rtl/gwm_dp.sv
rtl/glob_wildcard_matcher.sv
sim/glob_wildcard_matcher_test.sv
